// ===== rtl/core/ats_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg
// Shared widths, defaults, register indexes and scaling constants for the
// averaged temperature sampler.
// ----------------------------------------------------------------------------
package ats_pkg;

    // Default build parameters
    localparam int DEF_AVG_DEPTH = 10;
    localparam int DEF_ADC_BITS  = 12;

    // Register widths and reset values
    localparam int TICK_W      = 10;
    localparam int PERIOD_W    = 16;
    localparam int ELAPSED_W   = 17;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [TICK_W-1:0]   TICK_RESET   = 10'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TICK_INCREMENT = 1'b0,
        CFG_SAMPLE_PERIOD  = 1'b1
    } cfg_reg_t;

    // Result fields
    localparam int TEMP_C_W  = 12;
    localparam int TEMP_F_W  = 13;
    localparam int M_TDATA_W = 32;

    // Full scale in tenths of a degree: 3.3 V at 10 mV per degree
    localparam int FULL_SCALE_TENTHS = 3300;

    // Fahrenheit: F = C*9/5 + 320; divide by 5 as multiply by ceil(2^19/5)
    localparam int                  F_Y_W    = 16;
    localparam int                  F_SHIFT  = 19;
    localparam int                  F_PROD_W = 33;
    localparam logic [16:0]         F_RECIP  = 17'd104858;
    localparam logic [TEMP_F_W-1:0] F_OFFSET = 13'd320;

endpackage : ats_pkg
`default_nettype wire

// ===== rtl/core/averaged_temperature_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// averaged_temperature_sampler
// Moving average of converter codes over a ring of samples, scaled to tenths
// of a degree Celsius and Fahrenheit, one result per tick.
// ----------------------------------------------------------------------------
// Each item on the slave side is one system tick carrying a converter code.
// The block accepts one item per clock when the master side is not stalled
// and returns exactly one result per item. The rate is set by the input
// stage: elapsed time, the sample decision and the running window sum are
// all updated in the single cycle an item is accepted, so the next tick may
// follow right behind. Behind that stage the scaling runs as a four-register
// pipeline (Celsius multiply, hold and times nine, divide-by-five multiply,
// offset into the output register). Every stage advances on its own when the
// stage after it has room, so bubbles close up and a waiting result does not
// block new ticks until the whole pipeline is full. The sample ring is a
// small memory with one valid bit per entry; entries never written read as
// zero, so no clearing pass is needed after reset. Configuration must be
// written only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module averaged_temperature_sampler
    import ats_pkg::*;
#(
    parameter int AVG_DEPTH = DEF_AVG_DEPTH,
    parameter int ADC_BITS  = DEF_ADC_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // Configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]              cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]              cfg_wdata,

    // Tick stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: adc_code [ADC_BITS-1:0], zero padding above
    input  wire logic [((ADC_BITS+7)/8)*8-1:0]      s_tdata,

    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: temp_c_tenths [11:0], temp_f_tenths [24:12], zeros [31:25]
    output logic [M_TDATA_W-1:0]                    m_tdata,
    // m_tuser: updated [0]
    output logic                                    m_tuser
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int SLOT_W  = $clog2(AVG_DEPTH);
    localparam int SUM_MAX = AVG_DEPTH * ((1 << ADC_BITS) - 1);
    localparam int SUM_W   = $clog2(SUM_MAX + 1);

    // Celsius = floor(sum * 3300 / (AVG_DEPTH << ADC_BITS)), done as a
    // multiply by a rounded-up reciprocal; 2^CEL_K > SUM_MAX * CEL_DEN keeps
    // it exact for every reachable sum.
    localparam longint unsigned CEL_DEN  = longint'(AVG_DEPTH) << ADC_BITS;
    localparam int              CEL_K    = SUM_W + $clog2(CEL_DEN);
    localparam longint unsigned CEL_MULT =
        ((longint'(FULL_SCALE_TENTHS) << CEL_K) + CEL_DEN - 1) / CEL_DEN;
    localparam int              MULT_W   = $clog2(CEL_MULT + 1);
    localparam int              PROD_W   = (SUM_W + MULT_W > CEL_K + TEMP_C_W) ?
                                           (SUM_W + MULT_W) : (CEL_K + TEMP_C_W);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]   tick_inc_reg;
    logic [PERIOD_W-1:0] period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_inc_reg <= TICK_RESET;
            period_reg   <= PERIOD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_TICK_INCREMENT: tick_inc_reg <= cfg_wdata[TICK_W-1:0];
                CFG_SAMPLE_PERIOD:  period_reg   <= cfg_wdata[PERIOD_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic s_fire;

    assign rdy5     = !m_valid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = aresetn && rdy1;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= s_fire;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) v4_reg      <= v3_reg;
            if (rdy5) m_valid_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: elapsed time, sample decision, running sum
    // ------------------------------------------------------------------
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_sum;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [SUM_W-1:0]     window_sum_reg, sum_next;
    logic [ADC_BITS-1:0]  code;
    logic [ADC_BITS-1:0]  oldest;
    logic                 sample_hit;
    logic                 take_sample;

    logic [ADC_BITS-1:0]  ring_mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0] ring_vld_reg;
    logic [ADC_BITS-1:0]  rd_data_reg;
    logic                 rd_vld_reg;

    assign code        = s_tdata[ADC_BITS-1:0];
    assign elapsed_sum = elapsed_reg + ELAPSED_W'(tick_inc_reg);
    assign sample_hit  = elapsed_sum >= ELAPSED_W'(period_reg);
    assign take_sample = s_fire && sample_hit;

    // Entry under the write slot, prefetched; never-written entries read zero
    assign oldest   = rd_vld_reg ? rd_data_reg : '0;
    assign sum_next = window_sum_reg - SUM_W'(oldest) + SUM_W'(code);

    always_comb begin
        slot_next = slot_reg;
        if (take_sample) begin
            if (slot_reg == SLOT_W'(AVG_DEPTH - 1)) begin
                slot_next = '0;
            end else begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg    <= '0;
            slot_reg       <= '0;
            window_sum_reg <= '0;
            ring_vld_reg   <= '0;
            rd_vld_reg     <= 1'b0;
        end else begin
            if (s_fire) begin
                elapsed_reg <= sample_hit ? '0 : elapsed_sum;
            end
            if (take_sample) begin
                window_sum_reg         <= sum_next;
                ring_vld_reg[slot_reg] <= 1'b1;
            end
            slot_reg   <= slot_next;
            // Read address differs from the write slot whenever a write happens
            rd_vld_reg <= ring_vld_reg[slot_next];
        end
    end

    // Sample ring: write at the slot, prefetch the entry the slot moves to
    always_ff @(posedge aclk) begin
        if (take_sample) begin
            ring_mem[slot_reg] <= code;
        end
        rd_data_reg <= ring_mem[slot_next];
    end

    // Stage 1 payload
    logic             upd1_reg;
    logic [SUM_W-1:0] sum1_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            upd1_reg <= sample_hit;
            sum1_reg <= sample_hit ? sum_next : window_sum_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Celsius multiply
    // ------------------------------------------------------------------
    logic              upd2_reg;
    logic [PROD_W-1:0] prod2_reg;

    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2) begin
            upd2_reg  <= upd1_reg;
            prod2_reg <= PROD_W'(sum1_reg) * PROD_W'(CEL_MULT);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: hold Celsius, form C*9
    // ------------------------------------------------------------------
    logic [TEMP_C_W-1:0] held_c_reg, c_next;
    logic                upd3_reg;
    logic [F_Y_W-1:0]    y3_reg;

    assign c_next = upd2_reg ? prod2_reg[CEL_K +: TEMP_C_W] : held_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_c_reg <= '0;
        end else if (v2_reg && rdy3) begin
            held_c_reg <= c_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            upd3_reg <= upd2_reg;
            y3_reg   <= (F_Y_W'(c_next) << 3) + F_Y_W'(c_next);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: divide by five through the reciprocal
    // ------------------------------------------------------------------
    logic                upd4_reg;
    logic [TEMP_C_W-1:0] c4_reg;
    logic [F_PROD_W-1:0] prod4_reg;

    always_ff @(posedge aclk) begin
        if (v3_reg && rdy4) begin
            upd4_reg  <= upd3_reg;
            c4_reg    <= held_c_reg;
            prod4_reg <= F_PROD_W'(y3_reg) * F_PROD_W'(F_RECIP);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add the Fahrenheit offset into the output register
    // ------------------------------------------------------------------
    logic                m_upd_reg;
    logic [TEMP_C_W-1:0] m_temp_c_reg;
    logic [TEMP_F_W-1:0] m_temp_f_reg;

    always_ff @(posedge aclk) begin
        if (v4_reg && rdy5) begin
            m_upd_reg    <= upd4_reg;
            m_temp_c_reg <= c4_reg;
            m_temp_f_reg <= prod4_reg[F_SHIFT +: TEMP_F_W] + F_OFFSET;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_upd_reg;
    assign m_tdata  = {(M_TDATA_W - TEMP_C_W - TEMP_F_W)'(0), m_temp_f_reg, m_temp_c_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(AVG_DEPTH - 1))
        else $error("write slot left the ring");

    a_elapsed_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        take_sample |=> elapsed_reg == '0)
        else $error("elapsed time not cleared after a sample");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        window_sum_reg <= SUM_W'(SUM_MAX))
        else $error("window sum exceeds the ring's maximum");

    a_slot_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !take_sample |=> $stable(slot_reg))
        else $error("write slot moved without a sample");

    a_c_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_temp_c_reg <= TEMP_C_W'(FULL_SCALE_TENTHS))
        else $error("Celsius result above full scale");

endmodule : averaged_temperature_sampler
`default_nettype wire
